// ===== rtl/lcdnw_pkg.sv =====
// lcdnw_pkg: word types, op codes and byte constants for the lcd nibble writer
// no dependencies; used by every module under rtl
package lcdnw_pkg;

	localparam logic [1:0] OP_CMD  = 2'd0;
	localparam logic [1:0] OP_CHAR = 2'd1;
	localparam logic [1:0] OP_NUM  = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam logic [1:0] ROW_FIRST  = 2'd1;
	localparam logic [1:0] ROW_SECOND = 2'd2;

	localparam logic [7:0] CURSOR_ROW1 = 8'h80;
	localparam logic [7:0] CURSOR_ROW2 = 8'hC0;
	localparam logic [7:0] ASCII_ZERO  = 8'd48;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;
	localparam logic [7:0] ASCII_SPACE = 8'h20;
	localparam logic [9:0] MAG_LIMIT   = 10'd999;

	localparam int MAX_BYTES = 5;

	typedef struct packed {
		logic [1:0]         op;
		logic [7:0]         byte_value;
		logic [1:0]         row;
		logic [5:0]         column;
		logic signed [15:0] number;
	} req_word_t;

	typedef struct packed {
		logic [3:0] nibble;
		logic       reg_select;
		logic       last;
	} res_word_t;

	// one item's byte list, oldest byte at index 0
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [MAX_BYTES-1:0]      rs;
		logic [2:0]                nbytes;
	} desc_t;

endpackage

// ===== rtl/lcdnw_front.sv =====
// lcdnw_front: three-stage front end, decodes a request into a byte list
// depends on lcdnw_pkg
module lcdnw_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lcdnw_pkg::req_word_t request,
	output logic                full,
	output logic                q_push,
	input  logic                q_full,
	output lcdnw_pkg::desc_t    q_wdata
);

	logic adv1, adv2, adv3;

	logic        v_s1, v_s2, v_s3;
	logic [1:0]  op_s1, op_s2;
	logic [7:0]  byte_s1, byte_s2;
	logic        cur_en_s1, cur_en_s2;
	logic [7:0]  cur_byte_s1, cur_byte_s2;
	logic [7:0]  sign_s1, sign_s2;
	logic        mag_ok_s1, mag_ok_s2;
	logic [9:0]  mag_s1;
	logic [3:0]  hund_s2;
	logic [6:0]  rem_s2;
	lcdnw_pkg::desc_t desc_s3;

	logic [15:0] raw;
	logic        neg;
	logic [15:0] mag16;
	logic        cur_en;
	logic [7:0]  cur_byte;
	logic [3:0]  hund;
	logic [6:0]  rem;
	logic [3:0]  tens;
	logic [3:0]  units;
	lcdnw_pkg::desc_t desc;

	assign adv3   = !v_s3 || !q_full;
	assign adv2   = !v_s2 || adv3;
	assign adv1   = !v_s1 || adv2;
	assign full   = !adv1;
	assign q_push = v_s3;
	assign q_wdata = desc_s3;

	// stage 1 decode
	always_comb begin
		raw   = request.number;
		neg   = raw[15];
		mag16 = neg ? (~raw + 16'd1) : raw;
		case (request.row)
			lcdnw_pkg::ROW_FIRST: begin
				cur_en   = 1'b1;
				cur_byte = lcdnw_pkg::CURSOR_ROW1 + {2'b00, request.column};
			end
			lcdnw_pkg::ROW_SECOND: begin
				cur_en   = 1'b1;
				cur_byte = lcdnw_pkg::CURSOR_ROW2 + {2'b00, request.column};
			end
			default: begin
				cur_en   = 1'b0;
				cur_byte = lcdnw_pkg::CURSOR_ROW1;
			end
		endcase
	end

	// stage 2 hundreds digit by compare ladder
	always_comb begin
		hund = 4'd0;
		rem  = mag_s1[6:0];
		for (int k = 1; k < 10; k++) begin
			if (mag_s1 >= 10'(k * 100)) begin
				hund = 4'(k);
				rem  = 7'(mag_s1 - 10'(k * 100));
			end
		end
	end

	// stage 3 tens and units, then byte list
	always_comb begin
		tens  = 4'd0;
		units = rem_s2[3:0];
		for (int k = 1; k < 10; k++) begin
			if (rem_s2 >= 7'(k * 10)) begin
				tens  = 4'(k);
				units = 4'(rem_s2 - 7'(k * 10));
			end
		end
		desc = '0;
		case (op_s2)
			lcdnw_pkg::OP_CMD: begin
				desc.bytes[0] = byte_s2;
				desc.rs       = 5'b00000;
				desc.nbytes   = 3'd1;
			end
			lcdnw_pkg::OP_CHAR: begin
				desc.bytes[0] = byte_s2;
				desc.rs       = 5'b00001;
				desc.nbytes   = 3'd1;
			end
			lcdnw_pkg::OP_NUM: begin
				if (cur_en_s2) begin
					desc.bytes[0] = cur_byte_s2;
					desc.bytes[1] = sign_s2;
					desc.bytes[2] = lcdnw_pkg::ASCII_ZERO + {4'd0, hund_s2};
					desc.bytes[3] = lcdnw_pkg::ASCII_ZERO + {4'd0, tens};
					desc.bytes[4] = lcdnw_pkg::ASCII_ZERO + {4'd0, units};
					desc.rs       = 5'b11110;
					desc.nbytes   = mag_ok_s2 ? 3'd5 : 3'd2;
				end else begin
					desc.bytes[0] = sign_s2;
					desc.bytes[1] = lcdnw_pkg::ASCII_ZERO + {4'd0, hund_s2};
					desc.bytes[2] = lcdnw_pkg::ASCII_ZERO + {4'd0, tens};
					desc.bytes[3] = lcdnw_pkg::ASCII_ZERO + {4'd0, units};
					desc.rs       = 5'b11111;
					desc.nbytes   = mag_ok_s2 ? 3'd4 : 3'd1;
				end
			end
			default: begin
				desc.nbytes = 3'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			// unused op code is dropped here
			if (adv1) v_s1 <= push && (request.op != lcdnw_pkg::OP_NONE);
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			op_s1       <= request.op;
			byte_s1     <= request.byte_value;
			cur_en_s1   <= cur_en;
			cur_byte_s1 <= cur_byte;
			sign_s1     <= neg ? lcdnw_pkg::ASCII_MINUS : lcdnw_pkg::ASCII_SPACE;
			mag_ok_s1   <= (mag16 <= {6'd0, lcdnw_pkg::MAG_LIMIT});
			mag_s1      <= mag16[9:0];
		end
		if (adv2) begin
			op_s2       <= op_s1;
			byte_s2     <= byte_s1;
			cur_en_s2   <= cur_en_s1;
			cur_byte_s2 <= cur_byte_s1;
			sign_s2     <= sign_s1;
			mag_ok_s2   <= mag_ok_s1;
			hund_s2     <= hund;
			rem_s2      <= rem;
		end
		if (adv3) begin
			desc_s3 <= desc;
		end
	end

endmodule

// ===== rtl/lcdnw_queue.sv =====
// lcdnw_queue: short first-in first-out buffer of byte lists
// depends on lcdnw_pkg
module lcdnw_queue #(
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  lcdnw_pkg::desc_t wdata,
	output logic             q_full,
	input  logic             rd_en,
	output lcdnw_pkg::desc_t rdata,
	output logic             q_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	lcdnw_pkg::desc_t mem [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign q_full  = (count_q == CW'(DEPTH));
	assign q_empty = (count_q == '0);
	assign rdata   = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (wr_en && !rd_en) count_q <= count_q + CW'(1);
			else if (rd_en && !wr_en) count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_ptr_q] <= wdata;
	end

endmodule

// ===== rtl/lcdnw_back.sv =====
// lcdnw_back: nibble sequencer and result register
// depends on lcdnw_pkg
module lcdnw_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  lcdnw_pkg::desc_t     q_rdata,
	output logic                 q_pop,
	output logic                 empty,
	input  logic                 pop,
	output lcdnw_pkg::res_word_t result
);

	lcdnw_pkg::desc_t    cur_q;
	logic                cur_v_q;
	logic [3:0]          idx_q;
	lcdnw_pkg::res_word_t out_q;
	logic                out_v_q;

	logic [7:0] byte_sel;
	logic [3:0] nib;
	logic       at_end;
	logic       emit;

	always_comb begin
		byte_sel = cur_q.bytes[idx_q[3:1]];
		nib      = idx_q[0] ? byte_sel[3:0] : byte_sel[7:4];
		at_end   = (idx_q[3:1] == (cur_q.nbytes - 3'd1)) && idx_q[0];
		emit     = cur_v_q && (!out_v_q || pop);
		q_pop    = !q_empty && (!cur_v_q || (emit && at_end));
	end

	assign empty  = !out_v_q;
	assign result = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			idx_q   <= 4'd0;
			out_v_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_v_q <= 1'b1;
				idx_q   <= 4'd0;
			end else if (emit) begin
				if (at_end) cur_v_q <= 1'b0;
				else idx_q <= idx_q + 4'd1;
			end
			if (emit) out_v_q <= 1'b1;
			else if (pop) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= q_rdata;
		if (emit) begin
			out_q.nibble     <= nib;
			out_q.reg_select <= cur_q.rs[idx_q[3:1]];
			out_q.last       <= at_end;
		end
	end

endmodule

// ===== rtl/char_lcd_nibble_writer_top.sv =====
// char_lcd_nibble_writer_top: lcd 4-bit nibble writer, front decode, queue, back sequencer
// depends on lcdnw_pkg, lcdnw_front, lcdnw_queue, lcdnw_back
//
//   side    | handshake      | word
//   --------+----------------+--------------------------------------------
//   request | push / full    | op, byte_value, row, column, number
//   result  | pop / empty    | nibble, reg_select, last
//
// one request word accepted per cycle while the front pipeline can move
// the request word passes the front stages, the queue and the back item register before its first nibble is shown
// an item gives 2 to 10 nibbles, one per cycle while pop does not stall the result, set by the back sequencer
// op code 3 words are taken and give no result
// reset clears valid flags, queue pointers and count, and the nibble index only; a pop stall can back up to full
module char_lcd_nibble_writer_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  lcdnw_pkg::req_word_t request,
	output logic                 full,
	output logic                 empty,
	input  logic                 pop,
	output lcdnw_pkg::res_word_t result
);

	logic             q_push;
	logic             q_full;
	lcdnw_pkg::desc_t q_wdata;
	logic             q_pop;
	logic             q_empty;
	lcdnw_pkg::desc_t q_rdata;

	lcdnw_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.request (request),
		.full    (full),
		.q_push  (q_push),
		.q_full  (q_full),
		.q_wdata (q_wdata)
	);

	lcdnw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push && !q_full),
		.wdata   (q_wdata),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.rdata   (q_rdata),
		.q_empty (q_empty)
	);

	lcdnw_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_rdata (q_rdata),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue read while empty");

	a_desc_len: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_wdata.nbytes != 3'd0 && q_wdata.nbytes <= 3'd5))
		else $error("byte list length out of range");

	a_push_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && q_full) |=> (q_push && $stable(q_wdata)))
		else $error("front dropped a stalled byte list");

endmodule
